>>> sv/sula_pkg.sv
// Shared types and codes for the shortest unique length accumulator.
`default_nettype none

package sula_pkg;

   // Item kinds on the request channel
   localparam logic [1:0] KIND_LEAF   = 2'd0;
   localparam logic [1:0] KIND_BRANCH = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   localparam int         CFG_W       = 5;
   localparam logic [4:0] CFG_RESET   = 5'd16;
   localparam int         COUNT_W     = 32;
   localparam int         SUM_W       = 64;
   localparam int         WEIGHT_W    = 33;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD1,
      ST_RD2,
      ST_LCLR,
      ST_LFG,
      ST_LFG2,
      ST_LRD,
      ST_LCHK,
      ST_LB,
      ST_LNEXT,
      ST_LINC,
      ST_TMUL,
      ST_TADD,
      ST_BRF,
      ST_BRS,
      ST_BRC,
      ST_XR,
      ST_XS,
      ST_XC,
      ST_XN,
      ST_MRF,
      ST_MRS,
      ST_MWF,
      ST_MWS
   } state_type;

endpackage

`default_nettype wire

>>> sv/shortest_unique_length_accumulator.sv
// Top level: sequencer over the node count store and the sum matrix store.
//
// Usage:
//   req_* is a valid/ready channel of edge and read items. rsp_* is a
//   valid/ready channel that returns one beat per read item (kind 2):
//   the matrix entry and its echoed row and column. Edge items return nothing.
//   csr_wr_en/csr_wr_data write num_genomes; write only while the block idles.
// Work per item, from acceptance until the block is ready again:
//   read item: the sum store is read, then the result register loads.
//   leaf edge, first child: the father's counts become one for the genome
//     and zero elsewhere; otherwise the father's counts are scanned with
//     one or two matrix updates per genome seen, then the genome's count is incremented.
//   branching edge: unless first child, nonzero flags load and a pair scan
//     runs over rows and over columns per qualifying row, one matrix update
//     per pair; then the son merges into the father and is cleared.
//   Every matrix update is a read-multiply-add-write through the one
//   read port of the sum store; every count access uses the node store port.
// Reset: a clearing pass over every address zeroes both stores; req_ready
//   stays low meanwhile.
// Stall: a read result waits in the output register while edge items are
//   still accepted; a second read holds in its hand-off state, with req_ready
//   low, until the register frees.
`default_nettype none

module shortest_unique_length_accumulator #(
   parameter int MAX_GENOMES = 16,
   parameter int NODE_SLOTS  = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [4:0]  csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic        req_first_child,
   input  wire logic [31:0] req_father_depth,
   input  wire logic [5:0]  req_father_slot,
   input  wire logic [5:0]  req_son_slot,
   input  wire logic        req_son_present,
   input  wire logic [3:0]  req_genome,
   input  wire logic [3:0]  req_read_row,
   input  wire logic [3:0]  req_read_col,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_sum_value,
   output logic [3:0]       rsp_row_out,
   output logic [3:0]       rsp_col_out
);

   import sula_pkg::*;

   localparam int GW         = $clog2(MAX_GENOMES);
   localparam int CW         = $clog2(MAX_GENOMES + 1);
   localparam int NODE_DEPTH = NODE_SLOTS * MAX_GENOMES;
   localparam int SUM_DEPTH  = MAX_GENOMES * MAX_GENOMES;
   localparam int NAW        = $clog2(NODE_DEPTH);
   localparam int SAW        = $clog2(SUM_DEPTH);
   localparam int CLR_DEPTH  = (NODE_DEPTH > SUM_DEPTH) ? NODE_DEPTH : SUM_DEPTH;
   localparam int CLW        = $clog2(CLR_DEPTH);

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [CFG_W-1:0]       cfg_ff;
   logic [CW-1:0]          n_eff;
   logic [CW-1:0]          i_ff, i_in, j_ff, j_in;
   logic                   pass_ff, pass_in;
   logic [MAX_GENOMES-1:0] fnz_ff, fnz_in, snz_ff, snz_in, refnz, qnz;
   logic [COUNT_W-1:0]     fg_ff, fg_in, cnt_ff, cnt_in, tcnt_ff, tcnt_in, fv_ff, fv_in;
   logic [WEIGHT_W-1:0]    w_ff, w_in;
   logic [5:0]             fslot_ff, fslot_in, sslot_ff, sslot_in;
   logic [CW-1:0]          g_ff, g_in;
   logic [GW-1:0]          trow_ff, trow_in, tcol_ff, tcol_in;
   logic [SUM_W-1:0]       prod_ff, prod_in;
   logic                   rdzero_ff, rdzero_in;
   logic [3:0]             row_ff, row_in, col_ff, col_in;
   logic [CLW-1:0]         clr_ff, clr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]       rsp_sum_ff, rsp_sum_in;
   logic [3:0]             rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;

   logic               node_we;
   logic [NAW-1:0]     node_waddr, node_raddr;
   logic [COUNT_W-1:0] node_wdata, node_rdata;
   logic               sum_we;
   logic [SAW-1:0]     sum_waddr, sum_raddr;
   logic [SUM_W-1:0]   sum_wdata, sum_rdata;

   logic fslot_ok, sslot_ok, genome_ok, read_ok;

   function automatic logic [NAW-1:0] node_addr(input logic [5:0] slot,
                                                input logic [CW-1:0] idx);
      return NAW'(slot) * NAW'(MAX_GENOMES) + NAW'(idx);
   endfunction

   sula_ram #(.DATA_W(COUNT_W), .DEPTH(NODE_DEPTH)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (node_wdata),
      .rd_addr (node_raddr),
      .rd_data (node_rdata)
   );

   sula_ram #(.DATA_W(SUM_W), .DEPTH(SUM_DEPTH)) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_waddr),
      .wr_data (sum_wdata),
      .rd_addr (sum_raddr),
      .rd_data (sum_rdata)
   );

   // Clamp the genome count to the store size
   assign n_eff = (32'(cfg_ff) > MAX_GENOMES) ? CW'(MAX_GENOMES) : CW'(cfg_ff);

   assign fslot_ok  = 32'(req_father_slot) < NODE_SLOTS;
   assign sslot_ok  = 32'(req_son_slot) < NODE_SLOTS;
   assign genome_ok = 32'(req_genome) < 32'(n_eff);
   assign read_ok   = (32'(req_read_row) < 32'(n_eff)) && (32'(req_read_col) < 32'(n_eff));

   // Cross pass 0 takes father as reference, pass 1 the son
   assign refnz = pass_ff ? snz_ff : fnz_ff;
   assign qnz   = pass_ff ? fnz_ff : snz_ff;

   // Sum store address follows the current term
   assign sum_raddr = SAW'(trow_ff) * SAW'(MAX_GENOMES) + SAW'(tcol_ff);

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sum_value = rsp_sum_ff;
   assign rsp_row_out   = rsp_row_ff;
   assign rsp_col_out   = rsp_col_ff;

   // Next state and store controls
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pass_in      = pass_ff;
      fnz_in       = fnz_ff;
      snz_in       = snz_ff;
      fg_in        = fg_ff;
      cnt_in       = cnt_ff;
      tcnt_in      = tcnt_ff;
      fv_in        = fv_ff;
      w_in         = w_ff;
      fslot_in     = fslot_ff;
      sslot_in     = sslot_ff;
      g_in         = g_ff;
      trow_in      = trow_ff;
      tcol_in      = tcol_ff;
      prod_in      = prod_ff;
      rdzero_in    = rdzero_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      node_we      = 1'b0;
      node_waddr   = '0;
      node_wdata   = '0;
      node_raddr   = '0;
      sum_we       = 1'b0;
      sum_waddr    = sum_raddr;
      sum_wdata    = '0;

      case (state_ff)
         ST_CLEAR: begin
            node_we    = 32'(clr_ff) < NODE_DEPTH;
            node_waddr = clr_ff[NAW-1:0];
            sum_we     = 32'(clr_ff) < SUM_DEPTH;
            sum_waddr  = clr_ff[SAW-1:0];
            if (clr_ff == CLW'(CLR_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               w_in     = {1'b0, req_father_depth} + WEIGHT_W'(1);
               fslot_in = req_father_slot;
               sslot_in = req_son_slot;
               g_in     = CW'(req_genome);
               row_in   = req_read_row;
               col_in   = req_read_col;
               trow_in  = GW'(req_read_row);
               tcol_in  = GW'(req_read_col);
               i_in     = '0;
               j_in     = '0;
               pass_in  = 1'b0;
               case (req_kind)
                  KIND_READ: begin
                     rdzero_in = !read_ok;
                     state_in  = read_ok ? ST_RD1 : ST_RD2;
                  end
                  KIND_LEAF: begin
                     if (fslot_ok && genome_ok) begin
                        state_in = req_first_child ? ST_LCLR : ST_LFG;
                     end
                  end
                  KIND_BRANCH: begin
                     if (fslot_ok && req_son_present && sslot_ok) begin
                        state_in = req_first_child ? ST_MRF : ST_BRF;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RD1: begin
            state_in = ST_RD2;
         end
         ST_RD2: begin
            // Hold the read until the output register frees
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = rdzero_ff ? '0 : sum_rdata;
               rsp_row_in   = row_ff;
               rsp_col_in   = col_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_LCLR: begin
            if (i_ff == n_eff) begin
               state_in = ST_IDLE;
            end else begin
               node_we    = 1'b1;
               node_waddr = node_addr(fslot_ff, i_ff);
               node_wdata = (i_ff == g_ff) ? COUNT_W'(1) : '0;
               i_in       = i_ff + 1'b1;
            end
         end
         ST_LFG: begin
            node_raddr = node_addr(fslot_ff, g_ff);
            state_in   = ST_LFG2;
         end
         ST_LFG2: begin
            fg_in    = node_rdata;
            i_in     = '0;
            state_in = ST_LRD;
         end
         ST_LRD: begin
            if (i_ff == n_eff) begin
               state_in = ST_LINC;
            end else begin
               node_raddr = node_addr(fslot_ff, i_ff);
               state_in   = ST_LCHK;
            end
         end
         ST_LCHK: begin
            cnt_in = node_rdata;
            if ((i_ff != g_ff) && (node_rdata != '0)) begin
               trow_in  = i_ff[GW-1:0];
               tcol_in  = g_ff[GW-1:0];
               tcnt_in  = COUNT_W'(1);
               ret_in   = ST_LB;
               state_in = ST_TMUL;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_LRD;
            end
         end
         ST_LB: begin
            if (fg_ff == '0) begin
               trow_in  = g_ff[GW-1:0];
               tcol_in  = i_ff[GW-1:0];
               tcnt_in  = cnt_ff;
               ret_in   = ST_LNEXT;
               state_in = ST_TMUL;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_LRD;
            end
         end
         ST_LNEXT: begin
            i_in     = i_ff + 1'b1;
            state_in = ST_LRD;
         end
         ST_LINC: begin
            node_we    = 1'b1;
            node_waddr = node_addr(fslot_ff, g_ff);
            node_wdata = fg_ff + 1'b1;
            state_in   = ST_IDLE;
         end
         ST_TMUL: begin
            // Weight the count; the sum entry is read meanwhile
            prod_in  = SUM_W'({32'b0, tcnt_ff} * {31'b0, w_ff});
            state_in = ST_TADD;
         end
         ST_TADD: begin
            sum_we    = 1'b1;
            sum_wdata = sum_rdata + prod_ff;
            state_in  = ret_ff;
         end
         ST_BRF: begin
            if (i_ff == n_eff) begin
               i_in     = '0;
               state_in = ST_XR;
            end else begin
               node_raddr = node_addr(fslot_ff, i_ff);
               state_in   = ST_BRS;
            end
         end
         ST_BRS: begin
            fnz_in[i_ff[GW-1:0]] = node_rdata != '0;
            node_raddr = node_addr(sslot_ff, i_ff);
            state_in   = ST_BRC;
         end
         ST_BRC: begin
            snz_in[i_ff[GW-1:0]] = node_rdata != '0;
            i_in     = i_ff + 1'b1;
            state_in = ST_BRF;
         end
         ST_XR: begin
            if (i_ff == n_eff) begin
               i_in = '0;
               if (!pass_ff) begin
                  pass_in = 1'b1;
               end else begin
                  state_in = ST_MRF;
               end
            end else if (refnz[i_ff[GW-1:0]] && !qnz[i_ff[GW-1:0]]) begin
               j_in     = '0;
               state_in = ST_XS;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_XS: begin
            if (j_ff == n_eff) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_XR;
            end else if (qnz[j_ff[GW-1:0]]) begin
               node_raddr = node_addr(pass_ff ? fslot_ff : sslot_ff, j_ff);
               state_in   = ST_XC;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_XC: begin
            tcnt_in  = node_rdata;
            trow_in  = i_ff[GW-1:0];
            tcol_in  = j_ff[GW-1:0];
            ret_in   = ST_XN;
            state_in = ST_TMUL;
         end
         ST_XN: begin
            j_in     = j_ff + 1'b1;
            state_in = ST_XS;
         end
         ST_MRF: begin
            if (i_ff == n_eff) begin
               state_in = ST_IDLE;
            end else begin
               node_raddr = node_addr(fslot_ff, i_ff);
               state_in   = ST_MRS;
            end
         end
         ST_MRS: begin
            fv_in      = node_rdata;
            node_raddr = node_addr(sslot_ff, i_ff);
            state_in   = ST_MWF;
         end
         ST_MWF: begin
            node_we    = 1'b1;
            node_waddr = node_addr(fslot_ff, i_ff);
            node_wdata = fv_ff + node_rdata;
            state_in   = ST_MWS;
         end
         ST_MWS: begin
            // Drop the son count after the father write, so equal slots end at zero
            node_we    = 1'b1;
            node_waddr = node_addr(sslot_ff, i_ff);
            node_wdata = '0;
            i_in       = i_ff + 1'b1;
            state_in   = ST_MRF;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cfg_ff       <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         pass_ff      <= 1'b0;
         ret_ff       <= ST_IDLE;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         pass_ff      <= pass_in;
         ret_ff       <= ret_in;
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      fnz_ff     <= fnz_in;
      snz_ff     <= snz_in;
      fg_ff      <= fg_in;
      cnt_ff     <= cnt_in;
      tcnt_ff    <= tcnt_in;
      fv_ff      <= fv_in;
      w_ff       <= w_in;
      fslot_ff   <= fslot_in;
      sslot_ff   <= sslot_in;
      g_ff       <= g_in;
      trow_ff    <= trow_in;
      tcol_ff    <= tcol_in;
      prod_ff    <= prod_in;
      rdzero_ff  <= rdzero_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
   end

   // A product is always followed by its write-back
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TMUL) |=> (state_ff == ST_TADD))
      else $error("multiply not followed by sum write-back");

   // No item enters during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("item accepted during clearing pass");

   // A new result beat only comes from the read hand-off state
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff ##1 rsp_valid_ff) |-> $past(state_ff == ST_RD2))
      else $error("result appeared outside a read");

endmodule

`default_nettype wire

>>> sv/sula_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module sula_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> verif/sula_checker.sv
// Checker for the shortest unique length accumulator: predicts read beats and compares them.
`timescale 1ns / 1ps

module sula_checker
   import sula_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [4:0]  csr_wr_data,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic        req_first_child,
   input  wire logic [31:0] req_father_depth,
   input  wire logic [5:0]  req_father_slot,
   input  wire logic [5:0]  req_son_slot,
   input  wire logic        req_son_present,
   input  wire logic [3:0]  req_genome,
   input  wire logic [3:0]  req_read_row,
   input  wire logic [3:0]  req_read_col,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [63:0] rsp_sum_value,
   input  wire logic [3:0]  rsp_row_out,
   input  wire logic [3:0]  rsp_col_out,
   output int               fail_count,
   output int               pending
);

   localparam int SLOTS   = 64;
   localparam int GENOMES = 16;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [3:0]       row;
      logic [3:0]       col;
   } read_beat_type;

   logic [COUNT_W-1:0] leaf_counts [SLOTS][GENOMES];
   logic [SUM_W-1:0]   unique_sums [GENOMES][GENOMES];
   logic [4:0]         genomes_cfg;
   read_beat_type      read_queue [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic int active_genomes();
      return (genomes_cfg > GENOMES) ? GENOMES : int'(genomes_cfg);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // Add the weighted counts of one node against another into the sum matrix
   task automatic cross_add(int ref_slot, int qry_slot, logic [63:0] weight, int n);
      for (int r = 0; r < n; r++) begin
         if (leaf_counts[ref_slot][r] != 0 && leaf_counts[qry_slot][r] == 0) begin
            for (int s = 0; s < n; s++) begin
               if (leaf_counts[qry_slot][s] != 0)
                  unique_sums[r][s] += 64'(leaf_counts[qry_slot][s]) * weight;
            end
         end
      end
   endtask

   // Advance the predicted state by one accepted request beat
   task automatic predict_item();
      int            n;
      int            f;
      int            sn;
      int            g;
      logic [63:0]   weight;
      read_beat_type beat;
      n      = active_genomes();
      f      = int'(req_father_slot);
      sn     = int'(req_son_slot);
      g      = int'(req_genome);
      weight = 64'(req_father_depth) + 64'd1;
      case (req_kind)
         KIND_READ: begin
            beat.row = req_read_row;
            beat.col = req_read_col;
            beat.sum = (int'(req_read_row) < n && int'(req_read_col) < n) ?
                       unique_sums[req_read_row][req_read_col] : '0;
            read_queue.push_back(beat);
         end
         KIND_LEAF: begin
            if (g < n) begin
               if (req_first_child) begin
                  for (int i = 0; i < n; i++)
                     leaf_counts[f][i] = '0;
               end else begin
                  for (int i = 0; i < n; i++) begin
                     if (i != g && leaf_counts[f][i] != 0) begin
                        unique_sums[i][g] += weight;
                        if (leaf_counts[f][g] == 0)
                           unique_sums[g][i] += 64'(leaf_counts[f][i]) * weight;
                     end
                  end
               end
               leaf_counts[f][g] = leaf_counts[f][g] + 1;
            end
         end
         KIND_BRANCH: begin
            if (req_son_present) begin
               if (!req_first_child) begin
                  cross_add(f, sn, weight, n);
                  cross_add(sn, f, weight, n);
               end
               // merge son into father, then clear the son
               for (int i = 0; i < n; i++) begin
                  leaf_counts[f][i]  = leaf_counts[f][i] + leaf_counts[sn][i];
                  leaf_counts[sn][i] = '0;
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++)
            for (int i = 0; i < GENOMES; i++)
               leaf_counts[s][i] = '0;
         for (int r = 0; r < GENOMES; r++)
            for (int c = 0; c < GENOMES; c++)
               unique_sums[r][c] = '0;
         genomes_cfg = CFG_RESET;
         read_queue.delete();
      end else begin
         if (csr_wr_en)
            genomes_cfg = csr_wr_data;
         // check the response beat against the oldest expectation first
         if (rsp_valid && rsp_ready) begin
            if (read_queue.size() == 0) begin
               report_mismatch("unexpected beat", rsp_sum_value, '0);
            end else begin
               read_beat_type want;
               want = read_queue.pop_front();
               if (rsp_sum_value !== want.sum)
                  report_mismatch("sum_value", rsp_sum_value, want.sum);
               if (rsp_row_out !== want.row)
                  report_mismatch("row_out", 64'(rsp_row_out), 64'(want.row));
               if (rsp_col_out !== want.col)
                  report_mismatch("col_out", 64'(rsp_col_out), 64'(want.col));
            end
         end
         if (req_valid && req_ready)
            predict_item();
      end
      pending = read_queue.size();
   end

endmodule

>>> verif/tb.sv
// Top of the testbench: clock, reset, stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
   import sula_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int         DRAIN_WAIT  = 3000;
   localparam int         IDLE_LIMIT  = 20000;
   localparam int         PHASE_ITEMS = 155;

   typedef struct packed {
      logic [1:0]  kind;
      logic        first_child;
      logic [31:0] father_depth;
      logic [5:0]  father_slot;
      logic [5:0]  son_slot;
      logic        son_present;
      logic [3:0]  genome;
      logic [3:0]  read_row;
      logic [3:0]  read_col;
   } req_item_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        csr_wr_en        = 1'b0;
   logic [4:0]  csr_wr_data      = '0;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind         = '0;
   logic        req_first_child  = 1'b0;
   logic [31:0] req_father_depth = '0;
   logic [5:0]  req_father_slot  = '0;
   logic [5:0]  req_son_slot     = '0;
   logic        req_son_present  = 1'b0;
   logic [3:0]  req_genome       = '0;
   logic [3:0]  req_read_row     = '0;
   logic [3:0]  req_read_col     = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [63:0] rsp_sum_value;
   logic [3:0]  rsp_row_out;
   logic [3:0]  rsp_col_out;

   int fail_count;
   int pending;
   int idle_cycles = 0;
   int genomes_now = 16;
   bit quiet       = 1'b0;

   shortest_unique_length_accumulator dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_first_child(req_first_child), .req_father_depth(req_father_depth),
      .req_father_slot(req_father_slot), .req_son_slot(req_son_slot),
      .req_son_present(req_son_present), .req_genome(req_genome),
      .req_read_row(req_read_row), .req_read_col(req_read_col),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_sum_value(rsp_sum_value),
      .rsp_row_out(rsp_row_out), .rsp_col_out(rsp_col_out)
   );

   sula_checker u_checker (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_first_child(req_first_child), .req_father_depth(req_father_depth),
      .req_father_slot(req_father_slot), .req_son_slot(req_son_slot),
      .req_son_present(req_son_present), .req_genome(req_genome),
      .req_read_row(req_read_row), .req_read_col(req_read_col),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_sum_value(rsp_sum_value),
      .rsp_row_out(rsp_row_out), .rsp_col_out(rsp_col_out),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // End the run when no beat moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Response side: stall a random number of cycles before each beat
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   function automatic req_item_type make_item(logic [1:0] kind, logic first,
                                              logic [31:0] depth, logic [5:0] fslot,
                                              logic [5:0] sslot, logic son,
                                              logic [3:0] genome, logic [3:0] row,
                                              logic [3:0] col);
      req_item_type it;
      it.kind = kind;            it.first_child = first;    it.father_depth = depth;
      it.father_slot = fslot;    it.son_slot = sslot;       it.son_present = son;
      it.genome = genome;        it.read_row = row;         it.read_col = col;
      return it;
   endfunction

   // Mostly small slots and in-range genomes so that trees actually build up
   function automatic req_item_type random_item();
      req_item_type it;
      int           roll;
      int           top;
      top  = (genomes_now > 0) ? genomes_now - 1 : 0;
      roll = $urandom_range(0, 99);
      it.kind = (roll < 45) ? KIND_LEAF : (roll < 78) ? KIND_BRANCH :
                (roll < 97) ? KIND_READ : KIND_UNUSED;
      it.first_child = ($urandom_range(0, 4) == 0);
      it.son_present = ($urandom_range(0, 7) != 0);
      it.father_slot = ($urandom_range(0, 9) != 0) ? 6'($urandom_range(0, 7))
                                                   : 6'($urandom_range(0, 63));
      it.son_slot    = ($urandom_range(0, 9) != 0) ? 6'($urandom_range(0, 7))
                                                   : 6'($urandom_range(0, 63));
      it.genome   = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, top))
                                                : 4'($urandom_range(0, 15));
      it.read_row = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, top))
                                                : 4'($urandom_range(0, 15));
      it.read_col = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, top))
                                                : 4'($urandom_range(0, 15));
      case ($urandom_range(0, 19))
         0:       it.father_depth = '1;
         1:       it.father_depth = '0;
         2:       it.father_depth = $urandom;
         default: it.father_depth = 32'($urandom_range(0, 200));
      endcase
      return it;
   endfunction

   // Present one request beat and hold it until accepted
   task automatic send_item(req_item_type it);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= it.kind;
      req_first_child  <= it.first_child;
      req_father_depth <= it.father_depth;
      req_father_slot  <= it.father_slot;
      req_son_slot     <= it.son_slot;
      req_son_present  <= it.son_present;
      req_genome       <= it.genome;
      req_read_row     <= it.read_row;
      req_read_col     <= it.read_col;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Hold off until every read has returned and the last edge has settled
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_genomes(logic [4:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      genomes_now = (value > 16) ? 16 : int'(value);
   endtask

   initial begin
      logic [4:0] settings [7];
      settings = '{5'd31, 5'd1, 5'd0, 5'd5, 5'd2, 5'd9, 5'd16};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_genomes(5'd16);

      // directed: leaves at the depth extremes, merges, reads at the corners
      send_item(make_item(KIND_LEAF,   1'b1, 32'd0, 6'd0,  6'd0,  1'b0, 4'd0,  4'd0,  4'd0));
      send_item(make_item(KIND_LEAF,   1'b0, '1,    6'd0,  6'd0,  1'b0, 4'd1,  4'd0,  4'd0));
      send_item(make_item(KIND_LEAF,   1'b0, 32'd7, 6'd0,  6'd0,  1'b0, 4'd1,  4'd0,  4'd0));
      send_item(make_item(KIND_LEAF,   1'b1, 32'd3, 6'd63, 6'd0,  1'b0, 4'd15, 4'd0,  4'd0));
      send_item(make_item(KIND_LEAF,   1'b0, 32'd3, 6'd63, 6'd0,  1'b0, 4'd2,  4'd0,  4'd0));
      send_item(make_item(KIND_BRANCH, 1'b0, '1,    6'd0,  6'd63, 1'b1, 4'd0,  4'd0,  4'd0));
      send_item(make_item(KIND_READ,   1'b0, 32'd0, 6'd0,  6'd0,  1'b0, 4'd0,  4'd0,  4'd1));
      send_item(make_item(KIND_READ,   1'b0, 32'd0, 6'd0,  6'd0,  1'b0, 4'd0,  4'd1,  4'd0));
      send_item(make_item(KIND_READ,   1'b0, 32'd0, 6'd0,  6'd0,  1'b0, 4'd0,  4'd15, 4'd0));
      send_item(make_item(KIND_READ,   1'b0, 32'd0, 6'd0,  6'd0,  1'b0, 4'd0,  4'd0,  4'd15));
      send_item(make_item(KIND_UNUSED, 1'b1, '1,    '1,    '1,    1'b1, '1,    '1,    '1));
      // branch without a son changes nothing
      send_item(make_item(KIND_BRANCH, 1'b0, 32'd9, 6'd0,  6'd5,  1'b0, 4'd0,  4'd0,  4'd0));
      // father equal to son wipes the slot
      send_item(make_item(KIND_BRANCH, 1'b0, 32'd9, 6'd0,  6'd0,  1'b1, 4'd0,  4'd0,  4'd0));
      send_item(make_item(KIND_LEAF,   1'b0, 32'd4, 6'd0,  6'd0,  1'b0, 4'd3,  4'd0,  4'd0));
      send_item(make_item(KIND_BRANCH, 1'b1, 32'd2, 6'd1,  6'd0,  1'b1, 4'd0,  4'd0,  4'd0));
      send_item(make_item(KIND_READ,   1'b0, 32'd0, 6'd0,  6'd0,  1'b0, 4'd0,  4'd15, 4'd15));
      send_item(make_item(KIND_READ,   1'b0, 32'd0, 6'd0,  6'd0,  1'b0, 4'd0,  4'd15, 4'd2));

      // random phases, one register setting each, some without random gaps or stalls
      foreach (settings[p]) begin
         drain();
         write_genomes(settings[p]);
         quiet = (p % 3 == 2);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 59) == 0) begin
               req_valid <= 1'b0;
               while (pending != 0) @(posedge clock);
            end
            send_item(random_item());
         end
      end

      drain();
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
